[hw/rtl/csrast_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrast_pkg
// Shared types and constants of the clipped shape rasterizer: input modes,
// configuration register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package csrast_pkg;

  // default coordinate width, screen sizes saturate at 2^(COORD_BITS-1)
  localparam int COORD_BITS_DEF = 14;

  // fixed field widths
  localparam int SIZE_W   = 14;
  localparam int PIX_W    = 13;
  localparam int COORD_IN = 16;
  localparam int RAD_W    = 15;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = SIZE_W'(1280);
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = SIZE_W'(720);

  // input item modes
  typedef enum logic [1:0] {
    MODE_FILL_RECT    = 2'd0,
    MODE_OUTLINE_RECT = 2'd1,
    MODE_FILL_CIRCLE  = 2'd2,
    MODE_STEP         = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_FRAME_OFFSET  = 2'd2
  } cfg_idx_t;

endpackage

[hw/rtl/clipped_shape_rasterizer.sv]
`timescale 1ns / 1ps
// A step beat appears on the result channel in the cycle after it is taken.
// One input beat per cycle while in_ready is high; commands give no result beat.
// Input is taken whenever the single output register is empty or being drained.
// Reset (synchronous, active low) leaves the block idle, screen 1280 x 720,
// frame offset zero and an empty output register.
// ----------------------------------------------------------------------------
// clipped_shape_rasterizer
// Starts a filled rectangle, rectangle outline or filled circle clipped to the
// screen, and walks its candidate pixels in raster order, one per step beat.
// ----------------------------------------------------------------------------
module clipped_shape_rasterizer #(
  parameter int COORD_BITS = csrast_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command / step channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic signed [csrast_pkg::COORD_IN-1:0] in_x,
  input  logic signed [csrast_pkg::COORD_IN-1:0] in_y,
  input  logic signed [csrast_pkg::COORD_IN-1:0] in_width,
  input  logic signed [csrast_pkg::COORD_IN-1:0] in_height,
  input  logic signed [csrast_pkg::RAD_W-1:0]  in_radius,
  input  logic [csrast_pkg::DATA_W-1:0]        in_color,
  // pixel channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_write_pixel,
  output logic [csrast_pkg::PIX_W-1:0]         out_pixel_x,
  output logic [csrast_pkg::PIX_W-1:0]         out_pixel_y,
  output logic [csrast_pkg::DATA_W-1:0]        out_byte_address,
  output logic [csrast_pkg::DATA_W-1:0]        out_pixel_color,
  output logic                                 out_done_res,
  output logic                                 out_busy_res,
  // register write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [csrast_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csrast_pkg::DATA_W-1:0]        cfg_data
);

  localparam int CB         = COORD_BITS;
  localparam int SW         = 18;
  localparam int SCREEN_MAX = 1 << (COORD_BITS - 1);
  localparam int SIZE_W     = csrast_pkg::SIZE_W;
  localparam int PIX_W      = csrast_pkg::PIX_W;
  localparam int DW         = csrast_pkg::DATA_W;
  localparam int RW         = csrast_pkg::RAD_W;
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic signed [SW-1:0] ZERO_S = '0;

  // configuration registers
  logic [SIZE_W-1:0] screen_width_r, screen_width_nxt;
  logic [SIZE_W-1:0] screen_height_r, screen_height_nxt;
  logic [DW-1:0]     frame_offset_r, frame_offset_nxt;

  // shape state
  csrast_pkg::mode_t shape_kind_r, shape_kind_nxt;
  logic              active_r, active_nxt;
  logic [CB-1:0]     cursor_x_r, cursor_x_nxt;
  logic [CB-1:0]     cursor_y_r, cursor_y_nxt;
  logic [CB-1:0]     span_left_r, span_left_nxt;
  logic [CB-1:0]     span_right_r, span_right_nxt;
  logic [CB-1:0]     span_top_r, span_top_nxt;
  logic [CB-1:0]     span_bottom_r, span_bottom_nxt;
  logic signed [SW-1:0] center_x_r, center_x_nxt;
  logic signed [SW-1:0] center_y_r, center_y_nxt;
  logic [DW-1:0]     radius_squared_r, radius_squared_nxt;
  logic [DW-1:0]     shape_color_r, shape_color_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_write_pixel_r, out_write_pixel_nxt;
  logic [PIX_W-1:0]  out_pixel_x_r, out_pixel_x_nxt;
  logic [PIX_W-1:0]  out_pixel_y_r, out_pixel_y_nxt;
  logic [DW-1:0]     out_byte_address_r, out_byte_address_nxt;
  logic [DW-1:0]     out_pixel_color_r, out_pixel_color_nxt;
  logic              out_done_res_r, out_done_res_nxt;
  logic              out_busy_res_r, out_busy_res_nxt;

  csrast_pkg::mode_t in_mode_e;
  logic              in_fire;

  // saturated screen size
  logic [CB-1:0]     eff_w;
  logic [CB-1:0]     eff_h;
  logic signed [SW-1:0] eff_w_s;
  logic signed [SW-1:0] eff_h_s;

  // command geometry
  logic signed [SW-1:0] x_ext, y_ext, w_ext, h_ext, r_ext;
  logic signed [SW-1:0] x_hi, y_hi;
  logic signed [SW-1:0] x_lo_c, y_lo_c, x_hi_c, y_hi_c;
  logic                 cmd_live;
  logic signed [2*RW-1:0] r_sq;

  // step datapath
  logic signed [SW-1:0]   dx, dy;
  logic signed [2*SW-1:0] dx_sq, dy_sq;
  logic [2*SW:0]          dist_sq;
  logic                   in_disc;
  logic                   step_wr;
  logic                   step_last;
  logic                   outline_mid;
  logic [2*CB-1:0]        row_base;
  logic [DW-1:0]          pix_index;
  logic [DW-1:0]          step_addr;

  assign in_mode_e = csrast_pkg::mode_t'(in_mode);
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // screen size saturation
  assign eff_w = (DW'(screen_width_r) > DW'(SCREEN_MAX)) ? CB'(SCREEN_MAX) : CB'(screen_width_r);
  assign eff_h = (DW'(screen_height_r) > DW'(SCREEN_MAX)) ? CB'(SCREEN_MAX)
                                                          : CB'(screen_height_r);
  assign eff_w_s = $signed(SW'(eff_w));
  assign eff_h_s = $signed(SW'(eff_h));

  // shape bounds, exclusive on the high side, then clipped
  assign x_ext = {{(SW-16){in_x[15]}}, in_x};
  assign y_ext = {{(SW-16){in_y[15]}}, in_y};
  assign w_ext = {{(SW-16){in_width[15]}}, in_width};
  assign h_ext = {{(SW-16){in_height[15]}}, in_height};
  assign r_ext = {{(SW-RW){in_radius[RW-1]}}, in_radius};

  assign x_hi = (in_mode_e == csrast_pkg::MODE_FILL_CIRCLE) ? x_ext + r_ext + r_ext
                                                            : x_ext + w_ext;
  assign y_hi = (in_mode_e == csrast_pkg::MODE_FILL_CIRCLE) ? y_ext + r_ext + r_ext
                                                            : y_ext + h_ext;

  assign x_lo_c = x_ext[SW-1] ? ZERO_S : x_ext;
  assign y_lo_c = y_ext[SW-1] ? ZERO_S : y_ext;
  assign x_hi_c = (x_hi > eff_w_s) ? eff_w_s : x_hi;
  assign y_hi_c = (y_hi > eff_h_s) ? eff_h_s : y_hi;
  assign cmd_live = (x_lo_c < x_hi_c) && (y_lo_c < y_hi_c);

  assign r_sq = in_radius * in_radius;

  // circle membership of the current candidate
  assign dx      = $signed(SW'(cursor_x_r)) - center_x_r;
  assign dy      = $signed(SW'(cursor_y_r)) - center_y_r;
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign dist_sq = (2*SW+1)'($unsigned(dx_sq)) + (2*SW+1)'($unsigned(dy_sq));
  assign in_disc = dist_sq <= (2*SW+1)'(radius_squared_r);
  assign step_wr = (shape_kind_r != csrast_pkg::MODE_FILL_CIRCLE) || in_disc;

  // pixel byte address, wraps at 32 bits
  assign row_base  = cursor_y_r * eff_w;
  assign pix_index = DW'(cursor_x_r) + DW'(row_base);
  assign step_addr = frame_offset_r + {pix_index[DW-3:0], 2'b00};

  assign step_last   = (cursor_x_r == span_right_r) && (cursor_y_r == span_bottom_r);
  assign outline_mid = (shape_kind_r == csrast_pkg::MODE_OUTLINE_RECT) &&
                       (cursor_y_r != span_top_r) && (cursor_y_r != span_bottom_r);

  // next state
  always_comb begin
    screen_width_nxt     = screen_width_r;
    screen_height_nxt    = screen_height_r;
    frame_offset_nxt     = frame_offset_r;
    shape_kind_nxt       = shape_kind_r;
    active_nxt           = active_r;
    cursor_x_nxt         = cursor_x_r;
    cursor_y_nxt         = cursor_y_r;
    span_left_nxt        = span_left_r;
    span_right_nxt       = span_right_r;
    span_top_nxt         = span_top_r;
    span_bottom_nxt      = span_bottom_r;
    center_x_nxt         = center_x_r;
    center_y_nxt         = center_y_r;
    radius_squared_nxt   = radius_squared_r;
    shape_color_nxt      = shape_color_r;
    out_valid_nxt        = out_valid_r && !out_ready;
    out_write_pixel_nxt  = out_write_pixel_r;
    out_pixel_x_nxt      = out_pixel_x_r;
    out_pixel_y_nxt      = out_pixel_y_r;
    out_byte_address_nxt = out_byte_address_r;
    out_pixel_color_nxt  = out_pixel_color_r;
    out_done_res_nxt     = out_done_res_r;
    out_busy_res_nxt     = out_busy_res_r;

    // register writes
    if (cfg_valid) begin
      case (csrast_pkg::cfg_idx_t'(cfg_index))
        csrast_pkg::CFG_SCREEN_WIDTH:  screen_width_nxt  = cfg_data[SIZE_W-1:0];
        csrast_pkg::CFG_SCREEN_HEIGHT: screen_height_nxt = cfg_data[SIZE_W-1:0];
        csrast_pkg::CFG_FRAME_OFFSET:  frame_offset_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (in_fire) begin
      if (in_mode_e != csrast_pkg::MODE_STEP) begin
        // new shape, aborts any shape in progress
        shape_kind_nxt  = in_mode_e;
        shape_color_nxt = in_color;
        active_nxt      = cmd_live;
        span_left_nxt   = CB'(x_lo_c);
        span_right_nxt  = CB'(x_hi_c - ONE_S);
        span_top_nxt    = CB'(y_lo_c);
        span_bottom_nxt = CB'(y_hi_c - ONE_S);
        cursor_x_nxt    = CB'(x_lo_c);
        cursor_y_nxt    = CB'(y_lo_c);
        if (in_mode_e == csrast_pkg::MODE_FILL_CIRCLE) begin
          center_x_nxt       = x_ext + r_ext;
          center_y_nxt       = y_ext + r_ext;
          radius_squared_nxt = DW'($unsigned(r_sq));
        end
      end else begin
        // step beat, one result
        out_valid_nxt = 1'b1;
        if (!active_r) begin
          out_write_pixel_nxt  = 1'b0;
          out_pixel_x_nxt      = '0;
          out_pixel_y_nxt      = '0;
          out_byte_address_nxt = '0;
          out_pixel_color_nxt  = '0;
          out_done_res_nxt     = 1'b0;
          out_busy_res_nxt     = 1'b0;
        end else begin
          out_write_pixel_nxt  = step_wr;
          out_pixel_x_nxt      = PIX_W'(cursor_x_r);
          out_pixel_y_nxt      = PIX_W'(cursor_y_r);
          out_byte_address_nxt = step_addr;
          out_pixel_color_nxt  = shape_color_r;
          out_done_res_nxt     = step_last;
          out_busy_res_nxt     = 1'b1;

          // advance the cursor
          if (step_last) begin
            active_nxt = 1'b0;
          end else if (outline_mid) begin
            if ((cursor_x_r == span_left_r) && (span_left_r != span_right_r)) begin
              cursor_x_nxt = span_right_r;
            end else begin
              cursor_x_nxt = span_left_r;
              cursor_y_nxt = cursor_y_r + CB'(1);
            end
          end else if (cursor_x_r < span_right_r) begin
            cursor_x_nxt = cursor_x_r + CB'(1);
          end else begin
            cursor_x_nxt = span_left_r;
            cursor_y_nxt = cursor_y_r + CB'(1);
          end
        end
      end
    end
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r   <= csrast_pkg::SCREEN_WIDTH_RST;
      screen_height_r  <= csrast_pkg::SCREEN_HEIGHT_RST;
      frame_offset_r   <= '0;
      shape_kind_r     <= csrast_pkg::MODE_FILL_RECT;
      active_r         <= 1'b0;
      cursor_x_r       <= '0;
      cursor_y_r       <= '0;
      span_left_r      <= '0;
      span_right_r     <= '0;
      span_top_r       <= '0;
      span_bottom_r    <= '0;
      center_x_r       <= '0;
      center_y_r       <= '0;
      radius_squared_r <= '0;
      shape_color_r    <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      screen_width_r   <= screen_width_nxt;
      screen_height_r  <= screen_height_nxt;
      frame_offset_r   <= frame_offset_nxt;
      shape_kind_r     <= shape_kind_nxt;
      active_r         <= active_nxt;
      cursor_x_r       <= cursor_x_nxt;
      cursor_y_r       <= cursor_y_nxt;
      span_left_r      <= span_left_nxt;
      span_right_r     <= span_right_nxt;
      span_top_r       <= span_top_nxt;
      span_bottom_r    <= span_bottom_nxt;
      center_x_r       <= center_x_nxt;
      center_y_r       <= center_y_nxt;
      radius_squared_r <= radius_squared_nxt;
      shape_color_r    <= shape_color_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_write_pixel_r  <= out_write_pixel_nxt;
    out_pixel_x_r      <= out_pixel_x_nxt;
    out_pixel_y_r      <= out_pixel_y_nxt;
    out_byte_address_r <= out_byte_address_nxt;
    out_pixel_color_r  <= out_pixel_color_nxt;
    out_done_res_r     <= out_done_res_nxt;
    out_busy_res_r     <= out_busy_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_write_pixel  = out_write_pixel_r;
  assign out_pixel_x      = out_pixel_x_r;
  assign out_pixel_y      = out_pixel_y_r;
  assign out_byte_address = out_byte_address_r;
  assign out_pixel_color  = out_pixel_color_r;
  assign out_done_res     = out_done_res_r;
  assign out_busy_res     = out_busy_res_r;

endmodule

[test/clipped_shape_rasterizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_shape_rasterizer_test
// Self-checking bench for the shape rasterizer. A table of hand-picked beats
// runs first, then randomized shape and step streams over several screen and
// frame offset settings. Each step beat is predicted by the table or by a
// bit-exact pixel walk model, compared field by field on the pixel channel.
// ----------------------------------------------------------------------------
module clipped_shape_rasterizer_test;
  import csrast_pkg::*;

  localparam int SCREEN_LIMIT = 1 << (COORD_BITS_DEF - 1);
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 205;
  localparam int WALK_CAP     = 150;
  localparam int LONG_HOLD    = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_style_t;

  // one beat of the command / step channel
  typedef struct {
    mode_t                     mode;
    logic signed [COORD_IN-1:0] x;
    logic signed [COORD_IN-1:0] y;
    logic signed [COORD_IN-1:0] w;
    logic signed [COORD_IN-1:0] h;
    logic signed [RAD_W-1:0]    r;
    logic [DATA_W-1:0]          color;
  } shape_beat_t;

  // one beat of the pixel channel
  typedef struct {
    logic              wr;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] color;
    logic              done;
    logic              busy;
  } pixel_beat_t;

  typedef struct {
    shape_beat_t beat;
    bit          typed;
    pixel_beat_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_mode;
  logic signed [COORD_IN-1:0] in_x, in_y, in_width, in_height;
  logic signed [RAD_W-1:0] in_radius;
  logic [DATA_W-1:0] in_color;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_write_pixel;
  logic [PIX_W-1:0] out_pixel_x, out_pixel_y;
  logic [DATA_W-1:0] out_byte_address, out_pixel_color;
  logic out_done_res, out_busy_res;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // model state: registers and the shape walk
  logic [SIZE_W-1:0] scr_w, scr_h;
  logic [DATA_W-1:0] fb_base;
  mode_t cur_kind;
  bit span_busy;
  int cur_x, cur_y, sp_l, sp_r, sp_t, sp_b, ctr_x, ctr_y;
  longint rad_sq;
  logic [DATA_W-1:0] ink;

  pixel_beat_t pending_pixels[$];
  dir_row_t dir_rows[$];
  pixel_beat_t no_pix;
  int err_count = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  clipped_shape_rasterizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_width         (in_width),
    .in_height        (in_height),
    .in_radius        (in_radius),
    .in_color         (in_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_pixel  (out_write_pixel),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_byte_address (out_byte_address),
    .out_pixel_color  (out_pixel_color),
    .out_done_res     (out_done_res),
    .out_busy_res     (out_busy_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // screen size as seen by the walk, saturated
  function automatic int clip_size(logic [SIZE_W-1:0] s);
    return (s > SCREEN_LIMIT) ? SCREEN_LIMIT : int'(s);
  endfunction

  // clip the half-open bounds and start the walk
  function automatic void open_span(mode_t k, int x0, int x1, int y0, int y1);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > clip_size(scr_w)) x1 = clip_size(scr_w);
    if (y1 > clip_size(scr_h)) y1 = clip_size(scr_h);
    cur_kind = k;
    span_busy = (x0 < x1) && (y0 < y1);
    if (span_busy) begin
      sp_l = x0;
      sp_r = x1 - 1;
      sp_t = y0;
      sp_b = y1 - 1;
      cur_x = x0;
      cur_y = y0;
    end
  endfunction

  // advance the model by one beat, returns 1 when a pixel beat is due
  function automatic bit rasterize(input shape_beat_t b, output pixel_beat_t res);
    int xs, ys, ws, hs, rs;
    bit last;
    longint dx, dy;
    logic [31:0] lin;
    xs = int'(b.x);
    ys = int'(b.y);
    ws = int'(b.w);
    hs = int'(b.h);
    rs = int'(b.r);
    res = '{default: '0};
    case (b.mode)
      MODE_FILL_RECT, MODE_OUTLINE_RECT: begin
        ink = b.color;
        // a negative right or bottom edge draws nothing
        if (xs + ws < 0 || ys + hs < 0) begin
          cur_kind = b.mode;
          span_busy = 1'b0;
        end else begin
          open_span(b.mode, xs, xs + ws, ys, ys + hs);
        end
        return 1'b0;
      end
      MODE_FILL_CIRCLE: begin
        ink = b.color;
        ctr_x = xs + rs;
        ctr_y = ys + rs;
        rad_sq = longint'(rs) * longint'(rs);
        open_span(MODE_FILL_CIRCLE, xs, xs + 2 * rs, ys, ys + 2 * rs);
        return 1'b0;
      end
      default: ;
    endcase
    // step with no shape gives an all-zero beat
    if (!span_busy) return 1'b1;
    last = (cur_x == sp_r) && (cur_y == sp_b);
    res.wr = 1'b1;
    if (cur_kind == MODE_FILL_CIRCLE) begin
      dx = longint'(cur_x) - longint'(ctr_x);
      dy = longint'(cur_y) - longint'(ctr_y);
      res.wr = (dx * dx + dy * dy) <= rad_sq;
    end
    lin = cur_x + cur_y * clip_size(scr_w);
    res.px = cur_x[PIX_W-1:0];
    res.py = cur_y[PIX_W-1:0];
    res.addr = fb_base + {lin[29:0], 2'b00};
    res.color = ink;
    res.done = last;
    res.busy = 1'b1;
    // next candidate in raster order, outline middle rows visit the edges only
    if (last) begin
      span_busy = 1'b0;
    end else if (cur_kind == MODE_OUTLINE_RECT && cur_y != sp_t && cur_y != sp_b) begin
      if (cur_x == sp_l && sp_l != sp_r) begin
        cur_x = sp_r;
      end else begin
        cur_x = sp_l;
        cur_y++;
      end
    end else if (cur_x < sp_r) begin
      cur_x++;
    end else begin
      cur_x = sp_l;
      cur_y++;
    end
    return 1'b1;
  endfunction

  function automatic shape_beat_t mk_beat(mode_t m, int x, int y, int w, int h, int r,
                                          logic [DATA_W-1:0] c);
    shape_beat_t b;
    b.mode = m;
    b.x = x[COORD_IN-1:0];
    b.y = y[COORD_IN-1:0];
    b.w = w[COORD_IN-1:0];
    b.h = h[COORD_IN-1:0];
    b.r = r[RAD_W-1:0];
    b.color = c;
    return b;
  endfunction

  // step beat, the other fields are don't-care and get random bits
  function automatic shape_beat_t step_beat();
    return mk_beat(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic pixel_beat_t pix(bit wr, int px, int py, logic [DATA_W-1:0] addr,
                                      logic [DATA_W-1:0] c, bit done, bit busy);
    pixel_beat_t p;
    p.wr = wr;
    p.px = px[PIX_W-1:0];
    p.py = py[PIX_W-1:0];
    p.addr = addr;
    p.color = c;
    p.done = done;
    p.busy = busy;
    return p;
  endfunction

  task automatic add_row(input shape_beat_t b, input bit typed, input pixel_beat_t want);
    dir_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  // offer one beat in bursts with random gaps, predict it once taken
  task automatic send_beat(input shape_beat_t b, input bit typed, input pixel_beat_t want);
    pixel_beat_t got;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_mode   <= b.mode;
    in_x      <= b.x;
    in_y      <= b.y;
    in_width  <= b.w;
    in_height <= b.h;
    in_radius <= b.r;
    in_color  <= b.color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rasterize(b, got)) pending_pixels.push_back(typed ? want : got);
  endtask

  // register write, valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SCREEN_WIDTH:  scr_w = val[SIZE_W-1:0];
      CFG_SCREEN_HEIGHT: scr_h = val[SIZE_W-1:0];
      CFG_FRAME_OFFSET:  fb_base = val;
      default: ;
    endcase
  endtask

  // stop offering, wait for every expected pixel, then let commands settle
  task automatic drain(input int tail);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // pixel channel check against the oldest expectation
  always @(posedge clk) begin : pixel_check
    pixel_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel beat", out_byte_address, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_write_pixel !== want.wr)
          report_mismatch("write_pixel", 32'(out_write_pixel), 32'(want.wr));
        if (out_pixel_x !== want.px)
          report_mismatch("pixel_x", 32'(out_pixel_x), 32'(want.px));
        if (out_pixel_y !== want.py)
          report_mismatch("pixel_y", 32'(out_pixel_y), 32'(want.py));
        if (out_byte_address !== want.addr)
          report_mismatch("byte_address", out_byte_address, want.addr);
        if (out_pixel_color !== want.color)
          report_mismatch("pixel_color", out_pixel_color, want.color);
        if (out_done_res !== want.done)
          report_mismatch("done_res", 32'(out_done_res), 32'(want.done));
        if (out_busy_res !== want.busy)
          report_mismatch("busy_res", 32'(out_busy_res), 32'(want.busy));
      end
    end
  end

  // receiver: changing stall patterns, plus a long hold on request
  initial begin : receiver
    int hold_cnt;
    int tick;
    rx_style_t style;
    hold_cnt = 0;
    tick = 0;
    style = RX_ALWAYS;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 200 == 0) style = rx_style_t'($urandom_range(0, 3));
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (style)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
          default:   out_ready <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("clipped_shape_rasterizer_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    shape_beat_t b;
    int p, n, phase_items, ew, eh;
    logic [DATA_W-1:0] sw, sh, so;

    // known inputs from time zero
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_STEP;
    in_x = '0;
    in_y = '0;
    in_width = '0;
    in_height = '0;
    in_radius = '0;
    in_color = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data = '0;

    // model reset
    scr_w = SCREEN_WIDTH_RST;
    scr_h = SCREEN_HEIGHT_RST;
    fb_base = '0;
    cur_kind = MODE_FILL_RECT;
    span_busy = 1'b0;
    {cur_x, cur_y, sp_l, sp_r, sp_t, sp_b, ctr_x, ctr_y} = '0;
    rad_sq = 0;
    ink = '0;
    no_pix = pix(0, 0, 0, 0, 0, 0, 0);

    // directed beats on the reset screen, 1280 x 720 at offset zero
    add_row(step_beat(), 1'b1, no_pix);
    add_row(mk_beat(MODE_FILL_RECT, 0, 0, 2, 1, 0, 32'hDEAD_BEEF), 1'b0, no_pix);
    add_row(step_beat(), 1'b1, pix(1, 0, 0, 0, 32'hDEAD_BEEF, 0, 1));
    add_row(step_beat(), 1'b1, pix(1, 1, 0, 4, 32'hDEAD_BEEF, 1, 1));
    add_row(step_beat(), 1'b1, no_pix);
    // bottom right corner, clipped to one pixel
    add_row(mk_beat(MODE_FILL_RECT, 1279, 719, 100, 100, 0, 32'hFFFF_FFFF), 1'b0, no_pix);
    add_row(step_beat(), 1'b1, pix(1, 1279, 719, 32'd3686396, 32'hFFFF_FFFF, 1, 1));
    // negative right edge, negative bottom edge, edge at zero
    add_row(mk_beat(MODE_FILL_RECT, -5, 0, -1, 4, 0, 32'h1), 1'b0, no_pix);
    add_row(mk_beat(MODE_OUTLINE_RECT, 3, -32768, 4, 32767, 0, 32'h2), 1'b0, no_pix);
    add_row(mk_beat(MODE_FILL_RECT, -10, 3, 10, 5, 0, 32'h3), 1'b0, no_pix);
    add_row(step_beat(), 1'b1, no_pix);
    // extreme fields, circles off screen and with negative radius
    add_row(mk_beat(MODE_FILL_RECT, -32768, -32768, 32767, 32767, -16384, 0), 1'b0, no_pix);
    add_row(mk_beat(MODE_FILL_CIRCLE, 32767, 32767, -32768, -32768, 16383, '1), 1'b0,
            no_pix);
    add_row(mk_beat(MODE_FILL_CIRCLE, 0, 0, 32767, 32767, -16384, 32'h4), 1'b0, no_pix);
    add_row(step_beat(), 1'b1, no_pix);
    // outline 3 x 3, aborted by the next command after the first middle row
    add_row(mk_beat(MODE_OUTLINE_RECT, 10, 20, 3, 3, 0, 32'h1234_5678), 1'b0, no_pix);
    repeat (5) add_row(step_beat(), 1'b0, no_pix);
    // outline one pixel wide
    add_row(mk_beat(MODE_OUTLINE_RECT, 5, 5, 1, 3, 0, 32'h8765_4321), 1'b0, no_pix);
    repeat (3) add_row(step_beat(), 1'b0, no_pix);
    // circle of radius one, the corner candidate is not written
    add_row(mk_beat(MODE_FILL_CIRCLE, 0, 0, 0, 0, 1, 32'h00C0_FFEE), 1'b0, no_pix);
    repeat (4) add_row(step_beat(), 1'b0, no_pix);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    // random phases, each on its own screen setting
    for (p = 0; p < 8; p++) begin
      drain(4);
      case (p)
        0: begin sw = 32'hABCD_0040; sh = 48;    so = 32'h0000_1000; end
        1: begin sw = 1;             sh = 1;     so = 32'hFFFF_FFFC; end
        2: begin sw = 0;             sh = 30;    so = 32'h0000_0010; end
        3: begin sw = 16383;         sh = 16383; so = 32'hFFFF_FFFF; end
        4: begin sw = 8192;          sh = 8192;  so = 32'h8000_0000; end
        5: begin sw = 200;           sh = 0;     so = 32'h0000_0040; end
        default: begin
          sw = $urandom_range(1, 300);
          sh = $urandom_range(1, 300);
          so = $urandom;
        end
      endcase
      write_reg(CFG_SCREEN_WIDTH, sw);
      write_reg(CFG_SCREEN_HEIGHT, sh);
      write_reg(CFG_FRAME_OFFSET, so);
      if (p == 6) write_reg(CFG_SPARE, $urandom);
      cfg_valid <= 1'b0;
      // long receiver hold while commands and steps keep coming
      if (p == 0 || p == 4) hold_req = 1'b1;
      ew = clip_size(scr_w);
      eh = clip_size(scr_h);

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        b.mode = mode_t'($urandom_range(0, 2));
        b.color = $urandom;
        if ($urandom_range(0, 9) == 0) begin
          // any value the fields allow
          b.x = COORD_IN'($urandom);
          b.y = COORD_IN'($urandom);
          b.w = COORD_IN'($urandom);
          b.h = COORD_IN'($urandom);
          b.r = RAD_W'($urandom);
        end else begin
          // small shape around the visible area
          b.x = COORD_IN'($urandom_range(0, ew + 8) - 8);
          b.y = COORD_IN'($urandom_range(0, eh + 8) - 8);
          b.w = COORD_IN'($urandom_range(0, 14) - 2);
          b.h = COORD_IN'($urandom_range(0, 14) - 2);
          b.r = RAD_W'($urandom_range(0, 7) - 1);
        end
        send_beat(b, 1'b0, no_pix);
        phase_items++;
        // mostly walk the shape to its end, else abort it early
        if ($urandom_range(0, 9) < 7) begin
          n = 0;
          while (span_busy && n < WALK_CAP) begin
            send_beat(step_beat(), 1'b0, no_pix);
            n++;
            phase_items++;
          end
          n = $urandom_range(0, 2);
        end else begin
          n = $urandom_range(0, 10);
        end
        repeat (n) begin
          send_beat(step_beat(), 1'b0, no_pix);
          phase_items++;
        end
      end
    end

    drain(8);
    if (pending_pixels.size() != 0)
      report_mismatch("missing pixel beats", pending_pixels.size(), 0);
    if (err_count == 0)
      $display("clipped_shape_rasterizer_test: done, clean");
    else
      $display("clipped_shape_rasterizer_test: done, errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/csrast_pkg.sv
hw/rtl/clipped_shape_rasterizer.sv
test/clipped_shape_rasterizer_test.sv
